// ===== src/flhm_pkg.sv =====
// Shared types and constants of the frame latency histogram monitor.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package flhm_pkg;

  // Field widths fixed by the item formats.
  localparam int KIND_W      = 3;
  localparam int TS_W        = 32;
  localparam int QUANT_W     = 10;
  localparam int BIN_FIELD_W = 11;
  localparam int COUNT_W     = 32;
  localparam int SUM_W       = 48;
  localparam int HIST_W      = 32;

  // Quantile in thousandths after reset (95 percent).
  localparam logic [QUANT_W-1:0] QUANT_RESET = 10'd950;

  // Event kinds.
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REPORT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP    = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TS_W-1:0]   timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [BIN_FIELD_W-1:0] latency_quantile_bin;
    logic [BIN_FIELD_W-1:0] period_quantile_bin;
    logic [COUNT_W-1:0]     frames_completed;
    logic [COUNT_W-1:0]     periods_counted;
    logic [SUM_W-1:0]       period_total_us;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic clr_step;    // write zero to both histograms at the sweep address
    logic div_load;    // start both bin divisions, update period totals
    logic bin_write;   // write back the incremented bins
    logic walk_setup;  // compute quantile targets, clear accumulators
    logic walk_step;   // read both histograms at the sweep address
    logic out_load;    // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic running;
    logic frame_open;
    logic sweep_last;
    logic div_busy;
    logic walk_busy;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== src/flhm_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module flhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/flhm_bin_div.sv =====
// Two-stage reciprocal-multiplication divider that turns a timestamp difference
// into a rounded, clamped histogram bin index. No package dependency.
`timescale 1ns / 1ps

module flhm_bin_div #(
  parameter int BIN_COUNT    = 2048,
  parameter int BIN_WIDTH_US = 500
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [31:0]                  dist_i,
  output logic                         busy_o,
  output logic [$clog2(BIN_COUNT)-1:0] bin_o
);

  localparam int     AW      = $clog2(BIN_COUNT);
  localparam int     NUM_W   = 34;
  localparam longint DIVISOR = 2 * longint'(BIN_WIDTH_US);
  localparam longint LIMIT   = DIVISOR * longint'(BIN_COUNT);
  // Numerators below the clamp limit fit in N_W bits; the reciprocal is
  // rounded up with enough fraction bits to make the quotient exact there.
  localparam int     N_W     = $clog2(LIMIT);
  localparam int     SHIFT   = N_W + $clog2(DIVISOR);
  localparam int     RECIP_W = N_W + 2;
  localparam int     PROD_W  = N_W + RECIP_W;
  localparam longint RECIP   = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;

  localparam logic [NUM_W-1:0]   LIMIT_N  = NUM_W'(LIMIT);
  localparam logic [NUM_W-1:0]   HALF_BIN = NUM_W'(BIN_WIDTH_US);
  localparam logic [RECIP_W-1:0] RECIP_M  = RECIP_W'(RECIP);
  localparam logic [AW-1:0]      LAST_BIN = AW'(BIN_COUNT - 1);

  logic [N_W-1:0]    num_q;
  logic              clamp_q;
  logic              busy_q;
  logic [PROD_W-1:0] prod_q;
  logic [NUM_W-1:0]  numer;

  // Rounded numerator: twice the distance plus one bin width.
  assign numer = {1'b0, dist_i, 1'b0} + HALF_BIN;

  // The multiply stage runs in the cycle after a load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= load_i;
    end
  end

  // Stage one captures the numerator and the clamp flag, stage two multiplies
  // by the reciprocal of the bin width.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q   <= numer[N_W-1:0];
      clamp_q <= (numer >= LIMIT_N);
    end
    if (busy_q) begin
      prod_q <= PROD_W'(num_q) * PROD_W'(RECIP_M);
    end
  end

  assign busy_o = busy_q;
  assign bin_o  = clamp_q ? LAST_BIN : prod_q[SHIFT +: AW];

endmodule

// ===== src/flhm_datapath.sv =====
// Datapath of the monitor: event state, counters, two histogram lanes with
// bin dividers and quantile walk, and the result register.
// Depends on flhm_pkg, flhm_ram and flhm_bin_div.
`timescale 1ns / 1ps

module flhm_datapath import flhm_pkg::*; #(
  parameter int BIN_COUNT    = 2048,
  parameter int BIN_WIDTH_US = 500
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_status_t       status_o,
  input  in_item_t           in_data_i,
  input  logic               cfg_we_i,
  input  logic [QUANT_W-1:0] cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  localparam int AW      = $clog2(BIN_COUNT);
  localparam int PROD_W  = QUANT_W + COUNT_W;
  localparam int SCALE_W = HIST_W + 10;
  localparam int ACC_W   = SCALE_W + AW;
  localparam logic [AW-1:0] LAST_BIN = AW'(BIN_COUNT - 1);

  // Multiply a bin count by 1000 with shifts: 1024 - 16 - 8.
  function automatic logic [SCALE_W-1:0] scale_permille(input logic [HIST_W-1:0] x);
    scale_permille = SCALE_W'({x, 10'b0}) - SCALE_W'({x, 4'b0}) - SCALE_W'({x, 3'b0});
  endfunction

  function automatic logic [HIST_W-1:0] sat_inc(input logic [HIST_W-1:0] x);
    sat_inc = (x == '1) ? x : x + HIST_W'(1);
  endfunction

  logic [QUANT_W-1:0] quant_q, quant_d;
  logic               running_q, running_d;
  logic               frame_open_q, frame_open_d;
  logic               finish_seen_q, finish_seen_d;
  logic [TS_W-1:0]    start_time_q, start_time_d;
  logic [TS_W-1:0]    last_finish_q, last_finish_d;
  logic [COUNT_W-1:0] completed_q, completed_d;
  logic [COUNT_W-1:0] period_cnt_q, period_cnt_d;
  logic [SUM_W-1:0]   period_sum_q, period_sum_d;
  logic [TS_W-1:0]    lat_dist_q, lat_dist_d;
  logic [TS_W-1:0]    per_dist_q, per_dist_d;
  logic               per_en_q, per_en_d;
  logic [SUM_W:0]     sum_wide;
  logic               fin_ok;

  logic [AW-1:0]      sweep_q, sweep_d;
  logic               sweep_last;
  logic               v1_q, v2_q, v3_q;
  logic [AW-1:0]      idx1_q, idx2_q, idx3_q;

  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q;

  // Per-lane hookup: lane 0 is latency, lane 1 is period.
  logic [TS_W-1:0]        lane_dist [2];
  logic [COUNT_W-1:0]     lane_count [2];
  logic                   lane_wen [2];
  logic                   lane_busy [2];
  logic [BIN_FIELD_W-1:0] lane_res [2];

  assign fin_ok     = running_q & frame_open_q;
  assign sweep_last = (sweep_q == LAST_BIN);

  // Quantile writes, event handling on input transfers and period totals on division start.
  always_comb begin
    quant_d       = quant_q;
    running_d     = running_q;
    frame_open_d  = frame_open_q;
    finish_seen_d = finish_seen_q;
    start_time_d  = start_time_q;
    last_finish_d = last_finish_q;
    completed_d   = completed_q;
    period_cnt_d  = period_cnt_q;
    period_sum_d  = period_sum_q;
    lat_dist_d    = lat_dist_q;
    per_dist_d    = per_dist_q;
    per_en_d      = per_en_q;
    sum_wide      = {1'b0, period_sum_q} + (SUM_W + 1)'(per_dist_q);
    if (cfg_we_i) begin
      quant_d = cfg_data_i;
    end
    if (cmd_i.accept) begin
      case (in_data_i.kind)
        KIND_RESTART: begin
          running_d     = 1'b1;
          frame_open_d  = 1'b0;
          finish_seen_d = 1'b0;
          start_time_d  = '0;
          last_finish_d = '0;
          completed_d   = '0;
          period_cnt_d  = '0;
          period_sum_d  = '0;
        end
        KIND_BEGIN: begin
          if (running_q) begin
            start_time_d = in_data_i.timestamp_us;
            frame_open_d = 1'b1;
          end
        end
        KIND_FINISH, KIND_STOP: begin
          if (fin_ok) begin
            lat_dist_d    = in_data_i.timestamp_us - start_time_q;
            per_dist_d    = in_data_i.timestamp_us - last_finish_q;
            per_en_d      = finish_seen_q;
            last_finish_d = in_data_i.timestamp_us;
            finish_seen_d = 1'b1;
            frame_open_d  = 1'b0;
            if (completed_q != '1) begin
              completed_d = completed_q + COUNT_W'(1);
            end
          end
          if (in_data_i.kind == KIND_STOP) begin
            running_d    = 1'b0;
            frame_open_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.div_load && per_en_q) begin
      period_sum_d = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      if (period_cnt_q != '1) begin
        period_cnt_d = period_cnt_q + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant_q       <= QUANT_RESET;
      running_q     <= 1'b0;
      frame_open_q  <= 1'b0;
      finish_seen_q <= 1'b0;
      start_time_q  <= '0;
      last_finish_q <= '0;
      completed_q   <= '0;
      period_cnt_q  <= '0;
      period_sum_q  <= '0;
      per_en_q      <= 1'b0;
    end else begin
      quant_q       <= quant_d;
      running_q     <= running_d;
      frame_open_q  <= frame_open_d;
      finish_seen_q <= finish_seen_d;
      start_time_q  <= start_time_d;
      last_finish_q <= last_finish_d;
      completed_q   <= completed_d;
      period_cnt_q  <= period_cnt_d;
      period_sum_q  <= period_sum_d;
      per_en_q      <= per_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lat_dist_q <= lat_dist_d;
    per_dist_q <= per_dist_d;
  end

  // Sweep address shared by the clearing pass and the quantile walk.
  always_comb begin
    sweep_d = sweep_q;
    if (cmd_i.clr_step || cmd_i.walk_step) begin
      sweep_d = sweep_last ? '0 : sweep_q + AW'(1);
    end
  end

  // Walk pipeline: read, scale, accumulate, compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      sweep_q <= sweep_d;
      v1_q    <= cmd_i.walk_step;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= sweep_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
  end

  assign lane_dist[0]  = lat_dist_q;
  assign lane_dist[1]  = per_dist_q;
  assign lane_count[0] = completed_q;
  assign lane_count[1] = period_cnt_q;
  assign lane_wen[0]   = cmd_i.clr_step | cmd_i.bin_write;
  assign lane_wen[1]   = cmd_i.clr_step | (cmd_i.bin_write & per_en_q);

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [AW-1:0]      bin;
    logic [AW-1:0]      addr;
    logic [HIST_W-1:0]  rdata;
    logic [HIST_W-1:0]  wdata;
    logic [SCALE_W-1:0] scaled_q;
    logic [ACC_W-1:0]   acc_q, acc_d;
    logic [PROD_W-1:0]  prod_q;
    logic               found_q, found_d;
    logic [AW-1:0]      hit_idx_q;
    logic               hit;

    flhm_bin_div #(
      .BIN_COUNT   (BIN_COUNT),
      .BIN_WIDTH_US(BIN_WIDTH_US)
    ) u_div (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .load_i(cmd_i.div_load),
      .dist_i(lane_dist[g]),
      .busy_o(lane_busy[g]),
      .bin_o (bin)
    );

    // Sweep address for clearing and walking, else the divided bin.
    assign addr  = (cmd_i.clr_step || cmd_i.walk_step) ? sweep_q : bin;
    assign wdata = cmd_i.clr_step ? '0 : sat_inc(rdata);

    flhm_ram #(
      .WIDTH(HIST_W),
      .DEPTH(BIN_COUNT)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (lane_wen[g]),
      .waddr_i(addr),
      .wdata_i(wdata),
      .raddr_i(addr),
      .rdata_o(rdata)
    );

    // The bin is found once the scaled running sum reaches quantile times
    // count, and is at least one sample.
    assign hit = v3_q & ~found_q & (acc_q >= ACC_W'(prod_q)) & (acc_q != '0);

    always_comb begin
      acc_d   = acc_q;
      found_d = found_q;
      if (cmd_i.walk_setup) begin
        acc_d   = '0;
        found_d = 1'b0;
      end else begin
        if (v2_q) begin
          acc_d = acc_q + ACC_W'(scaled_q);
        end
        if (hit) begin
          found_d = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        found_q <= 1'b0;
      end else begin
        found_q <= found_d;
      end
    end

    always_ff @(posedge clk_i) begin
      scaled_q <= scale_permille(rdata);
      acc_q    <= acc_d;
      if (cmd_i.walk_setup) begin
        prod_q <= PROD_W'(quant_q) * PROD_W'(lane_count[g]);
      end
      if (hit) begin
        hit_idx_q <= idx3_q;
      end
    end

    assign lane_res[g] = (lane_count[g] == '0) ? '0 :
                         found_q ? BIN_FIELD_W'(hit_idx_q) : BIN_FIELD_W'(LAST_BIN);
  end

  // Result register parts the walk from the output stall.
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.latency_quantile_bin <= lane_res[0];
      out_data_q.period_quantile_bin  <= lane_res[1];
      out_data_q.frames_completed     <= completed_q;
      out_data_q.periods_counted      <= period_cnt_q;
      out_data_q.period_total_us      <= period_sum_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o.running    = running_q;
  assign status_o.frame_open = frame_open_q;
  assign status_o.sweep_last = sweep_last;
  assign status_o.div_busy   = lane_busy[0] | lane_busy[1];
  assign status_o.walk_busy  = v1_q | v2_q | v3_q;
  assign status_o.out_free   = ~out_valid_q | ~out_stall_i;

endmodule

// ===== src/flhm_ctrl.sv =====
// Controller state machine of the monitor: sequences clearing, binning,
// the quantile walk and the result transfer. Depends on flhm_pkg.
`timescale 1ns / 1ps

module flhm_ctrl import flhm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] in_kind_i,
  input  ctrl_status_t      status_i,
  output logic              in_stall_o,
  output ctrl_cmd_t         cmd_o
);

  localparam logic [3:0] ST_CLEAR  = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_LOAD   = 4'd2;
  localparam logic [3:0] ST_DIV    = 4'd3;
  localparam logic [3:0] ST_READ   = 4'd4;
  localparam logic [3:0] ST_WRITE  = 4'd5;
  localparam logic [3:0] ST_WSETUP = 4'd6;
  localparam logic [3:0] ST_WALK   = 4'd7;
  localparam logic [3:0] ST_DRAIN  = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       stop_q, stop_d;
  logic       fin_ok;

  assign fin_ok     = status_i.running & status_i.frame_open;
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    stop_d  = stop_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          stop_d       = (in_kind_i == KIND_STOP);
          case (in_kind_i)
            KIND_RESTART: state_d = ST_CLEAR;
            KIND_FINISH:  state_d = fin_ok ? ST_LOAD : ST_IDLE;
            KIND_REPORT:  state_d = ST_WSETUP;
            KIND_STOP:    state_d = fin_ok ? ST_LOAD : ST_WSETUP;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.bin_write = 1'b1;
        state_d         = stop_q ? ST_WSETUP : ST_IDLE;
      end
      ST_WSETUP: begin
        cmd_o.walk_setup = 1'b1;
        state_d          = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.walk_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      stop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      stop_q  <= stop_d;
    end
  end

endmodule

// ===== src/frame_latency_histogram_monitor_core.sv =====
// Top level of the frame latency histogram monitor.
// Depends on flhm_pkg, flhm_ctrl and flhm_datapath.
//
// Usage:
//   The input channel (in_valid_i, in_stall_o, in_data_i) carries events:
//   restart, begin frame, finish frame, report and stop, each with a
//   microsecond timestamp. A transfer happens when valid is high and stall
//   is low. Report and stop each produce one result on the output channel
//   (out_valid_o, out_stall_i, out_data_o); other events produce none.
//   The quantile register is written over cfg_valid_i / cfg_ready_o /
//   cfg_data_i; ready is always high. The user must write it only while the
//   block is idle, which the block itself does not enforce. Per event:
//   begin, ignored events: accepted while idle, with no further work.
//   finish: when it closes a frame, the two-stage reciprocal bin divider,
//   then the read-modify-write of the histogram memories.
//   report: quantile walk, one histogram bin read per cycle; the result is
//   valid in the cycle the input frees up.
//   stop: binning as for finish when it closes a frame, then as for report.
//   restart: a clearing pass, one clearing write per memory entry.
// Reset starts the same clearing pass over both histograms; the input is
// stalled until it ends. A stalled output holds its result, and a further
// report waits in the controller until the result register frees.
`timescale 1ns / 1ps

module frame_latency_histogram_monitor_core import flhm_pkg::*; #(
  parameter int BIN_COUNT    = 2048,
  parameter int BIN_WIDTH_US = 500
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [QUANT_W-1:0] cfg_data_i
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         cfg_we;

  // The register accepts a write in every cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  flhm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_kind_i (in_data_i.kind),
    .status_i  (status),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd)
  );

  flhm_datapath #(
    .BIN_COUNT   (BIN_COUNT),
    .BIN_WIDTH_US(BIN_WIDTH_US)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // No input transfer while the walk pipeline still holds bins.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.walk_busy |-> in_stall_o)
    else $error("input taken during quantile walk");

  // No input transfer while a bin division is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_busy |-> in_stall_o)
    else $error("input taken during bin division");

  // A result never overwrites one that is still stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  // The clearing pass never overlaps a bin update or a walk read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> (!cmd.bin_write && !cmd.walk_step))
    else $error("clearing pass overlaps histogram access");

endmodule
